>>> sv/grid_cell_blend_cache_top_defines.svh
// assertion macros used by the grid cell blend cache back end
`ifndef GRID_CELL_BLEND_CACHE_TOP_DEFINES_SVH
`define GRID_CELL_BLEND_CACHE_TOP_DEFINES_SVH

// checked at every edge outside reset
`define GCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define GCB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/gcb_pkg.sv
package gcb_pkg;

  localparam int GRID_COLS       = 256;
  localparam int GRID_ROWS       = 256;
  localparam int COORD_FRAC_BITS = 8;

  localparam int CELLS      = GRID_COLS * GRID_ROWS;
  localparam int IW         = $clog2(CELLS);
  localparam int COLW       = $clog2(GRID_COLS);
  localparam int ROWW       = $clog2(GRID_ROWS);
  // cells are half a metre: shift by one less than the fraction bits
  localparam int CELL_SHIFT = COORD_FRAC_BITS - 1;
  // cell coordinate relative to origin, with headroom for the subtract
  localparam int CW         = 26;

  localparam int COORD_W    = 24;
  localparam int REG_W      = 17;
  localparam int ALPHA_FRAC = 16;
  localparam logic [REG_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [REG_W-1:0] ALPHA_RESET = 17'd32768;
  localparam logic [REG_W-1:0] ORIGIN_RESET = 17'h1ff80;

  localparam int QDEPTH = 2;

  // register indexes
  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd2;

  typedef struct packed {
    logic [REG_W-1:0]        alpha;
    logic signed [REG_W-1:0] origin_x;
    logic signed [REG_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic                      mode;
    logic                      oow;
    logic [IW-1:0]             idx;
    logic signed [COORD_W-1:0] fresh_x;
    logic signed [COORD_W-1:0] fresh_y;
  } q_entry_t;

endpackage

>>> sv/gcb_front.sv
module gcb_front (
  input  logic                 rst,
  input  gcb_pkg::cfg_t        cfg,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [95:0]          s_tdata,   // world_x, world_y, fresh_x, fresh_y
  input  logic                 s_tuser,   // mode
  input  logic                 q_full,
  input  logic                 clr_busy,
  output logic                 q_push,
  output gcb_pkg::q_entry_t    q_entry
);
  import gcb_pkg::*;

  logic signed [COORD_W-1:0] world_x, world_y;
  logic signed [CW-1:0]      cx, cy;
  logic                      in_win;
  logic [COLW-1:0]           col;
  logic [ROWW-1:0]           row;

  assign world_x = s_tdata[23:0];
  assign world_y = s_tdata[47:24];

  // floor quantize, then relative to the window origin
  assign cx = CW'(world_x >>> CELL_SHIFT) - CW'(cfg.origin_x);
  assign cy = CW'(world_y >>> CELL_SHIFT) - CW'(cfg.origin_y);

  assign in_win = (cx >= 0) && (cx < CW'(GRID_COLS)) &&
                  (cy >= 0) && (cy < CW'(GRID_ROWS));

  assign col = cx[COLW-1:0];
  assign row = cy[ROWW-1:0];

  assign s_tready = !q_full && !clr_busy && !rst;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_entry.mode    = s_tuser;
    q_entry.oow     = !in_win;
    q_entry.idx     = IW'(row) * IW'(GRID_COLS) + IW'(col);
    q_entry.fresh_x = s_tdata[71:48];
    q_entry.fresh_y = s_tdata[95:72];
  end

endmodule

>>> sv/gcb_queue.sv
module gcb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gcb_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output gcb_pkg::q_entry_t head
);
  import gcb_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  q_entry_t        slots [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [NW-1:0]   count;

  assign full      = (count == NW'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/gcb_back.sv
`include "grid_cell_blend_cache_top_defines.svh"

module gcb_back (
  input  logic              clk,
  input  logic              rst,
  input  gcb_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  gcb_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              clr_busy,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // out_x, out_y
  output logic              m_tuser    // out_of_window
);
  import gcb_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;
  localparam logic [1:0] B_WR   = 2'd3;

  localparam int DW = COORD_W + 1;
  localparam int PW = REG_W + 1 + DW;

  logic [1:0]                state, state_next;
  q_entry_t                  cur;
  logic                      clr_active;
  logic [IW-1:0]             clr_addr;

  logic [2*COORD_W-1:0]      pt_mem [CELLS];
  logic                      v_mem  [CELLS];

  logic signed [COORD_W-1:0] old_x, old_y;
  logic                      old_v;
  logic                      do_blend;
  logic signed [PW-1:0]      prod_x, prod_y;

  logic [REG_W-1:0]          a_sat;
  logic signed [DW-1:0]      diff_x, diff_y;
  logic signed [COORD_W-1:0] res_x, res_y;
  logic                      out_free;
  logic                      wr_done;
  logic                      item_we;

  assign clr_busy = clr_active;
  assign q_pop    = (state == B_IDLE) && !clr_active && q_valid;
  assign out_free = !m_tvalid || m_tready;
  assign wr_done  = (state == B_WR) && out_free;
  assign item_we  = wr_done && !cur.oow;

  assign a_sat  = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign diff_x = DW'(cur.fresh_x) - DW'(old_x);
  assign diff_y = DW'(cur.fresh_y) - DW'(old_y);

  // arithmetic shift of the product floors it
  always_comb begin
    if (do_blend) begin
      res_x = old_x + prod_x[ALPHA_FRAC+COORD_W-1:ALPHA_FRAC];
      res_y = old_y + prod_y[ALPHA_FRAC+COORD_W-1:ALPHA_FRAC];
    end else begin
      res_x = cur.fresh_x;
      res_y = cur.fresh_y;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_pop) begin
          state_next = q_head.oow ? B_WR : B_READ;
        end
      end
      B_READ: state_next = B_MUL;
      B_MUL:  state_next = B_WR;
      B_WR: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // cell point store
  always_ff @(posedge clk) begin
    if (item_we) begin
      pt_mem[cur.idx] <= {res_y, res_x};
    end
    if (state == B_READ) begin
      {old_y, old_x} <= pt_mem[cur.idx];
    end
  end

  // valid store, swept to zero after reset
  always_ff @(posedge clk) begin
    if (clr_active) begin
      v_mem[clr_addr] <= 1'b0;
    end else if (item_we) begin
      v_mem[cur.idx] <= 1'b1;
    end
    if (state == B_READ) begin
      old_v <= v_mem[cur.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == B_IDLE) begin
      do_blend <= 1'b0;
    end else if (state == B_MUL) begin
      do_blend <= !cur.mode && old_v;
      prod_x   <= $signed({1'b0, a_sat}) * diff_x;
      prod_y   <= $signed({1'b0, a_sat}) * diff_y;
    end
    if (wr_done) begin
      m_tdata <= {res_y, res_x};
      m_tuser <= cur.oow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (clr_active) begin
        if (clr_addr == IW'(CELLS - 1)) begin
          clr_active <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (wr_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `GCB_ASSERT(a_no_pop_in_clear, clr_active |-> !q_pop, "queue popped during clear pass")
  `GCB_ASSERT(a_no_write_in_clear, item_we |-> !clr_active, "cell written during clear pass")
  `GCB_ASSERT(a_read_then_mul, (state == B_READ) |=> (state == B_MUL), "read not followed by multiply")
  `GCB_ASSERT(a_oow_skips_store, (q_pop && q_head.oow) |=> (state == B_WR), "outside cell went to store")
  `GCB_ASSERT_RST(a_clear_after_rst, rst |=> clr_active, "clear pass not started by reset")

endmodule

>>> sv/grid_cell_blend_cache_top.sv
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata world_x,world_y,fresh_x,fresh_y; tuser mode
// m_*       out  m_tvalid/m_tready    tdata out_x,out_y; tuser out_of_window
// cfg_*     in   cfg_we               cfg_idx register index, cfg_wdata value
//
// in the back end an in-window item passes through cell store read, blend multiply,
// add and write back; an out-of-window item skips the read and multiply
// the front end queues up to 2 requests while the back end or the output stalls
// reset starts a clear pass of the valid store over all GRID_COLS*GRID_ROWS cells
// (65536 as built), during which s_tready stays low
// a result waits in the output register until m_tready; the back end holds meanwhile
module grid_cell_blend_cache_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // world_x, world_y, fresh_x, fresh_y
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_x, out_y
  output logic        m_tuser,   // out_of_window
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [16:0] cfg_wdata
);
  import gcb_pkg::*;

  cfg_t     cfg;
  logic     q_full, q_valid, q_push, q_pop, clr_busy;
  q_entry_t q_entry, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha    <= ALPHA_RESET;
      cfg.origin_x <= ORIGIN_RESET;
      cfg.origin_y <= ORIGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ALPHA:    cfg.alpha    <= cfg_wdata;
        REG_ORIGIN_X: cfg.origin_x <= cfg_wdata;
        REG_ORIGIN_Y: cfg.origin_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gcb_front u_front (
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .clr_busy (clr_busy),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  gcb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  gcb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clr_busy (clr_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> test/tb_grid_cell_blend_cache_top.sv
module tb_grid_cell_blend_cache_top;
  import gcb_pkg::*;

  localparam logic MODE_BLEND     = 1'b0;
  localparam logic MODE_OVERWRITE = 1'b1;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_HOLD      = 8;
  localparam int DRAIN_TAIL     = 16;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 150;

  localparam longint CELL_SPAN = longint'(1) << CELL_SHIFT;
  // reachable cell indexes of a 24 bit coordinate
  localparam longint CELL_MAX  = (longint'(1) << (COORD_W - 1 - CELL_SHIFT)) - 1;
  localparam longint CELL_MIN  = -CELL_MAX - 1;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
  localparam logic signed [REG_W-1:0] ORIGIN_MIN  = 17'sh10000;
  localparam logic signed [REG_W-1:0] ORIGIN_MAX  = 17'sh0ffff;
  localparam logic [REG_W-1:0] ALPHA_OVER         = 17'h1ffff;

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
    logic signed [COORD_W-1:0] fresh_x;
    logic signed [COORD_W-1:0] fresh_y;
  } point_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      oow;
  } point_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // world_x, world_y, fresh_x, fresh_y
  logic        s_tuser = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // out_x, out_y
  logic        m_tuser;        // out_of_window
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [16:0] cfg_wdata = '0;

  grid_cell_blend_cache_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  // mirror of the configuration and the grid store
  logic [REG_W-1:0]          alpha_reg    = ALPHA_RESET;
  logic signed [REG_W-1:0]   origin_x_reg = ORIGIN_RESET;
  logic signed [REG_W-1:0]   origin_y_reg = ORIGIN_RESET;
  logic signed [COORD_W-1:0] grid_x [0:CELLS-1];
  logic signed [COORD_W-1:0] grid_y [0:CELLS-1];
  bit                        grid_filled [0:CELLS-1];

  point_res_t stored_point_q [$];

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int rx_hold = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_blend = 0;
  int n_fill = 0;
  int n_oow = 0;
  int n_cfg_writes = 0;

  function automatic point_res_t blend_cell(input point_req_t r);
    longint a, col, row, old_x, old_y, nx, ny;
    int idx;
    point_res_t res;
    a = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);
    col = (longint'($signed(r.world_x)) >>> CELL_SHIFT) - longint'(origin_x_reg);
    row = (longint'($signed(r.world_y)) >>> CELL_SHIFT) - longint'(origin_y_reg);
    nx = $signed(r.fresh_x);
    ny = $signed(r.fresh_y);
    res.oow = 1'b1;
    if (col >= 0 && col < GRID_COLS && row >= 0 && row < GRID_ROWS) begin
      idx = int'(row * GRID_COLS + col);
      res.oow = 1'b0;
      if (r.mode == MODE_BLEND && grid_filled[idx]) begin
        old_x = grid_x[idx];
        old_y = grid_y[idx];
        // arithmetic shift gives the floor of the weighted step
        nx = old_x + ((a * (nx - old_x)) >>> ALPHA_FRAC);
        ny = old_y + ((a * (ny - old_y)) >>> ALPHA_FRAC);
        n_blend++;
      end else begin
        n_fill++;
      end
      grid_x[idx] = nx[COORD_W-1:0];
      grid_y[idx] = ny[COORD_W-1:0];
      grid_filled[idx] = 1'b1;
    end else begin
      n_oow++;
    end
    res.out_x = nx[COORD_W-1:0];
    res.out_y = ny[COORD_W-1:0];
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic [31:0] v;
    v = $urandom();
    return v[COORD_W-1:0];
  endfunction

  function automatic point_req_t raw_req(input logic mode,
                                         input logic signed [COORD_W-1:0] wx,
                                         input logic signed [COORD_W-1:0] wy,
                                         input logic signed [COORD_W-1:0] fx,
                                         input logic signed [COORD_W-1:0] fy);
    point_req_t r;
    r.mode = mode;
    r.world_x = wx;
    r.world_y = wy;
    r.fresh_x = fx;
    r.fresh_y = fy;
    return r;
  endfunction

  // position somewhere inside window column col and row row
  function automatic point_req_t cell_req(input logic mode, input int col, input int row,
                                          input logic signed [COORD_W-1:0] fx,
                                          input logic signed [COORD_W-1:0] fy);
    longint wx, wy;
    wx = (longint'(origin_x_reg) + col) * CELL_SPAN + $urandom_range(0, CELL_SPAN - 1);
    wy = (longint'(origin_y_reg) + row) * CELL_SPAN + $urandom_range(0, CELL_SPAN - 1);
    return raw_req(mode, wx[COORD_W-1:0], wy[COORD_W-1:0], fx, fy);
  endfunction

  function automatic int border_of(input int n);
    case ($urandom_range(0, 3))
      0: return -1;
      1: return 0;
      2: return n - 1;
      default: return n;
    endcase
  endfunction

  function automatic point_req_t random_point(input point_req_t prev);
    int pick, col, row;
    bit raw;
    longint cx, cy;
    point_req_t r;
    pick = $urandom_range(0, 99);
    raw = 1'b0;
    col = 0;
    row = 0;
    if (pick < 15) begin
      r = prev;
    end else begin
      if (pick < 60) begin
        // small hot region so cells get blended many times
        col = $urandom_range(0, 7);
        row = $urandom_range(0, 7);
      end else if (pick < 75) begin
        col = $urandom_range(0, GRID_COLS - 1);
        row = $urandom_range(0, GRID_ROWS - 1);
      end else if (pick < 85) begin
        col = border_of(GRID_COLS);
        row = ($urandom_range(0, 1) == 0) ? border_of(GRID_ROWS)
                                           : $urandom_range(0, GRID_ROWS - 1);
      end else begin
        raw = 1'b1;
      end
      cx = longint'(origin_x_reg) + col;
      cy = longint'(origin_y_reg) + row;
      if (raw || cx < CELL_MIN || cx > CELL_MAX || cy < CELL_MIN || cy > CELL_MAX)
        r = raw_req(MODE_BLEND, rand_coord(), rand_coord(), '0, '0);
      else
        r = cell_req(MODE_BLEND, col, row, '0, '0);
    end
    r.mode = ($urandom_range(0, 3) == 0) ? MODE_OVERWRITE : MODE_BLEND;
    r.fresh_x = rand_coord();
    r.fresh_y = rand_coord();
    return r;
  endfunction

  function automatic int pick_gap(input bit enabled, input int long_max);
    int p;
    if (!enabled)
      return 0;
    p = $urandom_range(0, 99);
    if (p < 55)
      return 0;
    if (p < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%s", msg);
  endtask

  task automatic check_point_result();
    point_res_t want, got;
    got.out_x = m_tdata[COORD_W-1:0];
    got.out_y = m_tdata[2*COORD_W-1:COORD_W];
    got.oow = m_tuser;
    n_checked++;
    if (stored_point_q.size() == 0) begin
      flag_error($sformatf("unexpected result: x %0d y %0d oow %0b",
                           $signed(got.out_x), $signed(got.out_y), got.oow));
    end else begin
      want = stored_point_q.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y || got.oow !== want.oow)
        flag_error($sformatf("mismatch: expected x %0d y %0d oow %0b, got x %0d y %0d oow %0b",
                             $signed(want.out_x), $signed(want.out_y), want.oow,
                             $signed(got.out_x), $signed(got.out_y), got.oow));
    end
  endtask

  // result side: check, then choose the next ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (m_tvalid && m_tready)
        check_point_result();
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
        m_tready <= 1'b0;
        rx_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, stored_point_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_point(input point_req_t r);
    int gap;
    gap = pick_gap(tx_idle_on, 30);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.mode;
    s_tdata <= {r.fresh_y, r.fresh_x, r.world_y, r.world_x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    stored_point_q.push_back(blend_cell(r));
    n_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (stored_point_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] value);
    drain_results();
    repeat (IDLE_HOLD) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg_writes++;
    case (idx)
      REG_ALPHA:    alpha_reg = value;
      REG_ORIGIN_X: origin_x_reg = value;
      REG_ORIGIN_Y: origin_y_reg = value;
      default:      ;
    endcase
  endtask

  // reset configuration, back to back on one cell, borders and floor of negatives
  task automatic test_reset_config();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_point(cell_req(MODE_BLEND, 0, 0, 24'sd1000, -24'sd1000));
    send_point(cell_req(MODE_BLEND, 0, 0, 24'sd2000, 24'sd3000));
    send_point(cell_req(MODE_OVERWRITE, 0, 0, COORD_MIN, COORD_MAX));
    send_point(cell_req(MODE_BLEND, 0, 0, COORD_MAX, COORD_MIN));
    send_point(cell_req(MODE_OVERWRITE, GRID_COLS - 1, GRID_ROWS - 1,
                        rand_coord(), rand_coord()));
    send_point(cell_req(MODE_BLEND, GRID_COLS - 1, 0, rand_coord(), rand_coord()));
    send_point(cell_req(MODE_BLEND, -1, 0, rand_coord(), rand_coord()));
    send_point(cell_req(MODE_BLEND, GRID_COLS, 0, rand_coord(), rand_coord()));
    send_point(cell_req(MODE_BLEND, 0, -1, rand_coord(), rand_coord()));
    send_point(cell_req(MODE_OVERWRITE, 0, GRID_ROWS, rand_coord(), rand_coord()));
    send_point(raw_req(MODE_BLEND, COORD_MIN, COORD_MAX, rand_coord(), rand_coord()));
    // -1 lands in the cell below zero
    send_point(raw_req(MODE_BLEND, -24'sd1, 24'sd0, rand_coord(), rand_coord()));
  endtask

  task automatic test_alpha_range();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_reg(REG_ALPHA, '0);
    send_point(cell_req(MODE_BLEND, 0, 0, rand_coord(), rand_coord()));
    write_reg(REG_ALPHA, ALPHA_ONE);
    send_point(cell_req(MODE_BLEND, 0, 0, rand_coord(), rand_coord()));
    // above one saturates
    write_reg(REG_ALPHA, ALPHA_OVER);
    send_point(cell_req(MODE_BLEND, 0, 0, rand_coord(), rand_coord()));
    write_reg(REG_ALPHA, 17'd1);
    send_point(cell_req(MODE_BLEND, 0, 0, COORD_MIN, COORD_MIN));
    send_point(cell_req(MODE_BLEND, 0, 0, COORD_MAX, COORD_MAX));
  endtask

  task automatic test_origin_extremes();
    write_reg(REG_ORIGIN_X, ORIGIN_MIN);
    write_reg(REG_ORIGIN_Y, ORIGIN_MAX);
    send_point(raw_req(MODE_BLEND, COORD_MIN, COORD_MAX, rand_coord(), rand_coord()));
    send_point(raw_req(MODE_BLEND, COORD_MIN, COORD_MAX, rand_coord(), rand_coord()));
    write_reg(REG_ORIGIN_X, ORIGIN_MAX);
    write_reg(REG_ORIGIN_Y, ORIGIN_MIN);
    send_point(raw_req(MODE_BLEND, COORD_MAX, COORD_MIN, rand_coord(), rand_coord()));
    send_point(raw_req(MODE_BLEND, COORD_MAX - COORD_W'(CELL_SPAN), COORD_MIN,
                       rand_coord(), rand_coord()));
    // unknown index must leave every register alone
    write_reg(REG_UNUSED, ALPHA_OVER);
    send_point(raw_req(MODE_BLEND, COORD_MAX, COORD_MIN, rand_coord(), rand_coord()));
  endtask

  task automatic test_random_traffic();
    int v;
    point_req_t prev;
    prev = raw_req(MODE_BLEND, '0, '0, '0, '0);
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 4))
        0: write_reg(REG_ALPHA, '0);
        1: write_reg(REG_ALPHA, ALPHA_ONE);
        2: write_reg(REG_ALPHA, ALPHA_OVER);
        default: write_reg(REG_ALPHA, REG_W'($urandom_range(0, 65536)));
      endcase
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 4))
          3: v = $urandom();
          4: v = ($urandom_range(0, 1) == 0) ? int'(ORIGIN_MIN) : int'(ORIGIN_MAX);
          default: v = int'(ORIGIN_RESET) + $urandom_range(0, 8) - 4;
        endcase
        write_reg((k == 0) ? REG_ORIGIN_X : REG_ORIGIN_Y, v[REG_W-1:0]);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, REG_W'($urandom()));
      tx_idle_on = (p == 1 || p >= 3);
      rx_idle_on = (p >= 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2)
          drain_results();
        prev = random_point(prev);
        send_point(prev);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_alpha_range();
    test_origin_extremes();
    test_random_traffic();
    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("%0d requests, %0d results checked: %0d blends, %0d fills, %0d outside window",
             n_sent, n_checked, n_blend, n_fill, n_oow);
    $display("%0d register writes over %0d random phases, %0d mismatches",
             n_cfg_writes, PHASES, mismatch_count);
    if (mismatch_count == 0 && stored_point_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> grid_cell_blend_cache_top.f
+incdir+sv
sv/gcb_pkg.sv
sv/gcb_front.sv
sv/gcb_queue.sv
sv/gcb_back.sv
sv/grid_cell_blend_cache_top.sv
test/tb_grid_cell_blend_cache_top.sv
